// File: rtl/core/conv3x3_valid_stream_core_defines.svh
// assertion macros shared by the conv3x3 stream checker
`ifndef CONV3X3_VALID_STREAM_CORE_DEFINES_SVH
`define CONV3X3_VALID_STREAM_CORE_DEFINES_SVH

// property checked only while out of reset
`define C3VS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define C3VS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/c3vs_pkg.sv
// shared types and constants of the 3x3 convolution stream core
package c3vs_pkg;

    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int PIX_W       = 8;
    localparam int CONV_W      = 28;
    localparam int BIAS_W      = 24;
    localparam int IMG_WIDTH_W = 9;
    localparam int IMG_HEIGHT_W = 16;
    localparam int WROW_W      = 48;
    localparam int TAPS        = 9;
    localparam int REG_SHIFT   = 3;

    typedef enum logic [2:0] {
        REG_WEIGHTS_TOP = 3'd0,
        REG_WEIGHTS_MID = 3'd1,
        REG_WEIGHTS_BOT = 3'd2,
        REG_BIAS        = 3'd3,
        REG_IMAGE_WIDTH = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

endpackage

// File: rtl/core/conv3x3_valid_stream_core.sv
// 3x3 valid-mode convolution over a raster pixel stream with two line stores
// a pixel passes the input register and then the output register before its result is shown
// throughput: one pixel per cycle unless a stalled result holds the flow; the input register holds the
// pixel and the line store reads, one pass of window shift, products and sum feeds the result register
// reset: async, clears counters, window, valids and configuration registers to defaults;
// line stores are not cleared
module conv3x3_valid_stream_core
    import c3vs_pkg::*;
#(
    parameter int MAX_WIDTH   = 256,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [PIX_W-1:0]         pixel,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [CONV_W-1:0] conv_value,
    output logic                     frame_last
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int EW     = (CNT_W + 1 > IMG_WIDTH_W) ? CNT_W + 1 : IMG_WIDTH_W;
    localparam int HW     = IMG_HEIGHT_W + 1;
    localparam int EXT_W  = (3 * WEIGHT_BITS > WROW_W) ? 3 * WEIGHT_BITS : WROW_W;
    localparam int PW     = WEIGHT_BITS + PIX_W + 1;
    localparam int SUM_W  = (PW + 4 > CONV_W) ? PW + 4 : CONV_W;

    // configuration registers
    logic [WROW_W-1:0]       wtop_reg, wmid_reg, wbot_reg;
    logic [BIAS_W-1:0]       bias_reg;
    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;

    // position counters
    logic [CNT_W-1:0]        col_reg, col_next;
    logic [IMG_HEIGHT_W-1:0] row_reg, row_next;

    // line stores and their read registers
    pix_t line_a_mem [MAX_WIDTH];
    pix_t line_b_mem [MAX_WIDTH];
    pix_t rd_a_reg, rd_b_reg;

    // input register: pixel waiting for the window update
    logic             s1_v_reg, s1_prod_reg, s1_last_reg;
    pix_t             s1_pix_reg;
    logic [CNT_W-1:0] s1_slot_reg;

    // window
    pix_t window_reg [TAPS];
    pix_t window_next [TAPS];

    // products of the shifted window
    logic signed [PW-1:0] prod [TAPS];

    // output register
    logic                     out_v_reg;
    logic signed [CONV_W-1:0] conv_reg;
    logic                     last_reg;

    logic accept, out_free, s1_move, s1_free;
    logic cfg_write;
    cfg_reg_t cfg_idx;
    logic [EW-1:0] eff_w, col_inc;
    logic [HW-1:0] eff_h, row_inc;
    logic col_wrap, row_wrap, produce, last;
    logic [EXT_W-1:0] wrow_ext [3];
    logic signed [WEIGHT_BITS-1:0] weight [TAPS];
    logic signed [SUM_W-1:0] sum;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = cfg_reg_t'(paddr[ADDR_W-1:REG_SHIFT]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wtop_reg   <= '0;
            wmid_reg   <= '0;
            wbot_reg   <= '0;
            bias_reg   <= '0;
            width_reg  <= IMG_WIDTH_W'(3);
            height_reg <= IMG_HEIGHT_W'(3);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_WEIGHTS_TOP:  wtop_reg   <= pwdata[WROW_W-1:0];
                REG_WEIGHTS_MID:  wmid_reg   <= pwdata[WROW_W-1:0];
                REG_WEIGHTS_BOT:  wbot_reg   <= pwdata[WROW_W-1:0];
                REG_BIAS:         bias_reg   <= pwdata[BIAS_W-1:0];
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[IMG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[IMG_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WEIGHTS_TOP:  prdata = DATA_W'(wtop_reg);
            REG_WEIGHTS_MID:  prdata = DATA_W'(wmid_reg);
            REG_WEIGHTS_BOT:  prdata = DATA_W'(wbot_reg);
            REG_BIAS:         prdata = DATA_W'(bias_reg);
            REG_IMAGE_WIDTH:  prdata = DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    assign out_free = !out_v_reg || !out_stall;
    // items without a result leave the input register without a slot downstream
    assign s1_move  = s1_v_reg && (!s1_prod_reg || out_free);
    assign s1_free  = !s1_v_reg || s1_move;
    assign in_stall = !s1_free;
    assign accept   = in_valid && s1_free;

    // ---------------- position tracking ----------------
    always_comb
    begin
        if (width_reg < IMG_WIDTH_W'(3))
            eff_w = EW'(3);
        else if (EW'(width_reg) > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(width_reg);
        if (height_reg < IMG_HEIGHT_W'(3))
            eff_h = HW'(3);
        else
            eff_h = HW'(height_reg);
        col_inc  = EW'(col_reg) + EW'(1);
        row_inc  = HW'(row_reg) + HW'(1);
        col_wrap = col_inc >= eff_w;
        row_wrap = row_inc >= eff_h;
        produce  = (row_reg >= IMG_HEIGHT_W'(2)) && (col_reg >= CNT_W'(2));
        last     = col_wrap && row_wrap;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_inc[IMG_HEIGHT_W-1:0];
        end
        else
        begin
            col_next = col_inc[CNT_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line stores ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_a_reg <= line_a_mem[col_reg];
            rd_b_reg <= line_b_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            line_a_mem[s1_slot_reg] <= s1_pix_reg;
            line_b_mem[s1_slot_reg] <= rd_a_reg;
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (s1_free)
            s1_v_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixel;
            s1_slot_reg <= col_reg;
            s1_prod_reg <= produce;
            s1_last_reg <= last;
        end
    end

    // ---------------- window shift ----------------
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            window_next[r*3]   = window_reg[r*3+1];
            window_next[r*3+1] = window_reg[r*3+2];
        end
        window_next[2] = rd_b_reg;
        window_next[5] = rd_a_reg;
        window_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
                window_reg[i] <= '0;
        end
        else if (s1_move)
        begin
            window_reg <= window_next;
        end
    end

    // ---------------- products ----------------
    // weights past the 48-bit register read as zero
    assign wrow_ext[0] = EXT_W'(wtop_reg);
    assign wrow_ext[1] = EXT_W'(wmid_reg);
    assign wrow_ext[2] = EXT_W'(wbot_reg);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                weight[r*3+c] = wrow_ext[r][c*WEIGHT_BITS +: WEIGHT_BITS];
        for (int i = 0; i < TAPS; i++)
            prod[i] = PW'($signed({1'b0, window_next[i]})) * PW'(weight[i]);
    end

    // ---------------- output: sum plus bias ----------------
    always_comb
    begin
        sum = SUM_W'($signed(bias_reg));
        for (int i = 0; i < TAPS; i++)
            sum = sum + SUM_W'(prod[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_free)
            out_v_reg <= s1_move && s1_prod_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_prod_reg)
        begin
            conv_reg <= sum[CONV_W-1:0];
            last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign conv_value = conv_reg;
    assign frame_last = last_reg;

endmodule

// File: rtl/core/c3vs_checker.sv
// port-level checks of the 3x3 convolution stream core, bound to the core module
`include "conv3x3_valid_stream_core_defines.svh"

module c3vs_checker
    import c3vs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [ADDR_W-1:0]        paddr,
    input logic [DATA_W-1:0]        pwdata,
    input logic [DATA_W-1:0]        prdata,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [CONV_W-1:0] conv_value,
    input logic                     frame_last
);

    localparam logic [ADDR_W-1:0] WIDTH_ADDR = ADDR_W'(REG_IMAGE_WIDTH) << REG_SHIFT;
    localparam logic [ADDR_W-1:0] BIAS_ADDR  = ADDR_W'(REG_BIAS) << REG_SHIFT;

    // a held result stays
    `C3VS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

    `C3VS_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(conv_value) && $stable(frame_last), "stalled result changed")

    // no result shows while reset is applied, unknown before the first reset edge
    `C3VS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> out_valid !== 1'b1, "result valid during reset")

    // width read right after a width write returns the written bits
    `C3VS_ASSERT(a_width_readback, clk, rst_n, (psel && !pwrite && paddr == WIDTH_ADDR && $past(rst_n) && $past(psel && penable && pwrite && paddr == WIDTH_ADDR)) |-> prdata == DATA_W'($past(pwdata[IMG_WIDTH_W-1:0])), "image width readback mismatch")

    `C3VS_ASSERT(a_bias_readback, clk, rst_n, (psel && !pwrite && paddr == BIAS_ADDR && $past(rst_n) && $past(psel && penable && pwrite && paddr == BIAS_ADDR)) |-> prdata == DATA_W'($past(pwdata[BIAS_W-1:0])), "bias readback mismatch")

endmodule

bind conv3x3_valid_stream_core c3vs_checker u_c3vs_checker (.*);

// File: tb/tb_top.sv
// self-checking bench for the 3x3 valid-mode convolution stream core
module tb_top;
    import c3vs_pkg::*;

    localparam int LINE_MAX      = 256;
    localparam int WT_W          = 16;
    localparam int CLK_HALF      = 4;
    localparam int PIXEL_TARGET  = 1850;
    localparam int TIMEOUT_CYC   = 400000;
    localparam int SETTLE_CYC    = 8;
    localparam int DRAIN_LIMIT   = 20000;

    typedef enum int unsigned {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } idle_phase_t;

    typedef struct {
        logic [CONV_W-1:0] conv;
        logic              last;
    } conv_sum_t;

    class conv_window_model;
        logic [WROW_W-1:0]       weight_row [3];
        logic [BIAS_W-1:0]       bias;
        logic [IMG_WIDTH_W-1:0]  width_reg;
        logic [IMG_HEIGHT_W-1:0] height_reg;
        pix_t                    row_above [LINE_MAX];
        pix_t                    row_two_above [LINE_MAX];
        pix_t                    window [TAPS];
        int unsigned             col;
        int unsigned             row;
        conv_sum_t               pending_sums [$];
        int                      errors;

        function new();
            foreach (weight_row[i])
            begin
                weight_row[i] = '0;
            end
            foreach (row_above[i])
            begin
                row_above[i]     = '0;
                row_two_above[i] = '0;
            end
            foreach (window[i])
            begin
                window[i] = '0;
            end
            bias       = '0;
            width_reg  = 3;
            height_reg = 3;
            col        = 0;
            row        = 0;
            errors     = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [DATA_W-1:0] v);
            case (r)
                REG_WEIGHTS_TOP:  weight_row[0] = v[WROW_W-1:0];
                REG_WEIGHTS_MID:  weight_row[1] = v[WROW_W-1:0];
                REG_WEIGHTS_BOT:  weight_row[2] = v[WROW_W-1:0];
                REG_BIAS:         bias = v[BIAS_W-1:0];
                REG_IMAGE_WIDTH:  width_reg = v[IMG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = v[IMG_HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned active_width();
            if (width_reg < 3)
                return 3;
            if (width_reg > LINE_MAX)
                return LINE_MAX;
            return width_reg;
        endfunction

        function void take_pixel(pix_t p);
            int unsigned       w;
            int unsigned       h;
            int unsigned       slot;
            int                r;
            int                c;
            pix_t              top;
            pix_t              mid;
            longint            acc;
            logic signed [WT_W-1:0] wt;
            conv_sum_t         sum;
            w    = active_width();
            h    = (height_reg < 3) ? 3 : height_reg;
            slot = col % LINE_MAX;
            top  = row_two_above[slot];
            mid  = row_above[slot];
            row_two_above[slot] = mid;
            row_above[slot]     = p;
            for (r = 0; r < 3; r++)
            begin
                window[3*r]   = window[3*r+1];
                window[3*r+1] = window[3*r+2];
            end
            window[2] = top;
            window[5] = mid;
            window[8] = p;
            if (row >= 2 && col >= 2)
            begin
                acc = $signed(bias);
                for (r = 0; r < 3; r++)
                begin
                    for (c = 0; c < 3; c++)
                    begin
                        wt  = weight_row[r][WT_W*c +: WT_W];
                        acc += longint'(window[3*r+c]) * wt;
                    end
                end
                sum.conv = acc[CONV_W-1:0];
                sum.last = (row + 1 >= h) && (col + 1 >= w);
                pending_sums.push_back(sum);
            end
            if (col + 1 >= w)
            begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end
            else
            begin
                col++;
            end
        endfunction

        function void match_sum(logic [CONV_W-1:0] conv, logic last);
            conv_sum_t want;
            if (pending_sums.size() == 0)
            begin
                $error("unexpected result: conv_value %0d frame_last %0b", $signed(conv), last);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            if (conv !== want.conv)
            begin
                $error("conv_value: expected %0d, got %0d", $signed(want.conv), $signed(conv));
                errors++;
            end
            if (last !== want.last)
            begin
                $error("frame_last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    pix_t                     pixel = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [CONV_W-1:0] conv_value;
    logic                     frame_last;

    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      pixels_sent = 0;
    conv_window_model conv_model = new();

    conv3x3_valid_stream_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .conv_value (conv_value),
        .frame_last (frame_last)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // result side: check accepted items, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            conv_model.match_sum(conv_value, frame_last);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        #(TIMEOUT_CYC * 2 * CLK_HALF);
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_reg(input cfg_reg_t r, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(r) << REG_SHIFT);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        conv_model.set_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // leaves valid high; the caller sends again or lowers it in the same step
    task automatic send_pixel(input pix_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            pixel    <= pix_t'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        conv_model.take_pixel(p);
        pixels_sent++;
    endtask

    // warm-up pixels give no result, so give the pipe time to empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (conv_model.pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_phase(input idle_phase_t ph);
        case (ph)
            PH_STEADY:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PH_SEND_IDLE:
            begin
                send_idle_pct  = 50;
                recv_stall_pct = 0;
            end
            PH_RECV_STALL:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 50;
            end
            default:
            begin
                send_idle_pct  = 27;
                recv_stall_pct = 27;
            end
        endcase
    endtask

    function automatic logic [DATA_W-1:0] random_weight_row();
        logic [DATA_W-1:0] v;
        int                k;
        v = '0;
        case ($urandom_range(2))
            0: v = {$urandom, $urandom};
            1:
            begin
                for (k = 0; k < 3; k++)
                    v[WT_W*k +: WT_W] = WT_W'($signed($urandom_range(1023)) - 512);
            end
            default:
            begin
                for (k = 0; k < 3; k++)
                begin
                    case ($urandom_range(3))
                        0: v[WT_W*k +: WT_W] = 16'h8000;
                        1: v[WT_W*k +: WT_W] = 16'h7FFF;
                        2: v[WT_W*k +: WT_W] = 16'hFFFF;
                        default: v[WT_W*k +: WT_W] = 16'h0000;
                    endcase
                end
            end
        endcase
        return {16'h0, v[WROW_W-1:0]};
    endfunction

    // width only shrinks mid-image so no line store entry is read unwritten
    task automatic reshape_mid_image(input bit both);
        int unsigned pick;
        wait_idle();
        pick = both ? 2 : $urandom_range(2);
        if (pick != 1)
            write_reg(REG_IMAGE_WIDTH, DATA_W'(($urandom_range(5) == 0) ? $urandom_range(2)
                                       : $urandom_range(3, conv_model.active_width())));
        if (pick != 0)
            write_reg(REG_IMAGE_HEIGHT, DATA_W'($urandom_range(8)));
    endtask

    initial
    begin
        int unsigned i;
        int unsigned img;
        int unsigned n;
        int unsigned cut_at;
        int unsigned w;
        int unsigned guard;
        bit          tall;
        pix_t        p;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme weights and bias, all pixels at full scale
        set_phase(PH_STEADY);
        write_reg(REG_WEIGHTS_TOP, 64'h0000_7FFF_8000_0100);
        write_reg(REG_WEIGHTS_MID, 64'h0000_FFFF_0001_8000);
        write_reg(REG_WEIGHTS_BOT, 64'h0000_7FFF_7FFF_7FFF);
        write_reg(REG_BIAS, 64'h7F_FFFF);
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        for (i = 0; i < 9; i++)
            send_pixel(8'hFF);
        wait_idle();

        // most negative sum; width and height below the minimum act as 3
        write_reg(REG_WEIGHTS_TOP, 64'h0000_8000_8000_8000);
        write_reg(REG_WEIGHTS_MID, 64'h0000_8000_8000_8000);
        write_reg(REG_WEIGHTS_BOT, 64'h0000_8000_8000_8000);
        write_reg(REG_BIAS, 64'h80_0000);
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 0);
        for (i = 0; i < 9; i++)
            send_pixel(8'hFF);
        wait_idle();
        write_reg(REG_WEIGHTS_MID, 64'h0000_0100_FF00_0100);
        write_reg(REG_IMAGE_WIDTH, 2);
        for (i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'h00 : 8'hFF);

        img = 0;
        while (pixels_sent < PIXEL_TARGET)
        begin
            set_phase(idle_phase_t'(img % 4));
            wait_idle();
            write_reg(REG_WEIGHTS_TOP, random_weight_row());
            write_reg(REG_WEIGHTS_MID, random_weight_row());
            write_reg(REG_WEIGHTS_BOT, random_weight_row());
            write_reg(REG_BIAS, ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                : DATA_W'($urandom_range(4095)));
            tall   = (img == 7);
            cut_at = 0;
            if (img == 2)
            begin
                // above the line store size, acts as the full width
                write_reg(REG_IMAGE_WIDTH, 511);
                write_reg(REG_IMAGE_HEIGHT, 3);
            end
            else if (tall)
            begin
                // tallest image, cut short after a few rows
                w = $urandom_range(3, 5);
                write_reg(REG_IMAGE_WIDTH, DATA_W'(w));
                write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
                cut_at = 8 * w + $urandom_range(w - 1);
            end
            else
            begin
                write_reg(REG_IMAGE_WIDTH, DATA_W'(($urandom_range(9) == 0) ? $urandom_range(2)
                                           : $urandom_range(3, 10)));
                write_reg(REG_IMAGE_HEIGHT, DATA_W'(($urandom_range(7) == 0) ? $urandom_range(2)
                                            : $urandom_range(3, 6)));
                if ($urandom_range(4) == 0)
                    cut_at = $urandom_range(1, 30);
            end
            n = 0;
            do
            begin
                if ($urandom_range(7) == 0)
                    p = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    p = pix_t'($urandom);
                send_pixel(p);
                n++;
                if (n == cut_at && !(conv_model.col == 0 && conv_model.row == 0))
                    reshape_mid_image(tall);
            end
            while (!(conv_model.col == 0 && conv_model.row == 0));
            img++;
        end

        in_valid <= 1'b0;
        guard = 0;
        while (conv_model.pending_sums.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
        if (conv_model.pending_sums.size() != 0)
        begin
            $error("%0d results never arrived", conv_model.pending_sums.size());
            conv_model.errors++;
        end
        if (conv_model.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
